// File: rtl/core/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, register codes and the exp factor table of the Gaussian
// transfer color block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtc_pkg;

	// exponent of the curve: fixed point with 24 fraction bits, 28 bits total
	localparam int EXP_FRAC = 24;
	localparam int EXP_BITS = 28;

	// exp(-2^-24) in Q0.64, first entry of the squaring chain
	localparam logic [63:0] EXP_SEED = 64'hFFFF_FF00_0000_7FFF;

	// configuration port
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER           = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH            = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_OPACITY     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_COLOR_LEFT  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEAK_COLOR_RIGHT = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_COLOR_LEFT  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_COLOR_RIGHT = 3'd6;

	// sideband that travels with each sample down the pipeline
	typedef struct packed {
		logic valid;
		logic left;   // sample below center: left color pair
		logic zero;   // exponent out of range: weight is zero
	} tag_t;

	// the four colors, R in the top byte; lo = below center, hi = at or above
	typedef struct packed {
		logic [31:0] peak_lo;
		logic [31:0] peak_hi;
		logic [23:0] base_lo;
		logic [23:0] base_hi;
	} colors_t;

	// factor for exponent bit k: exp(-2^(k-24)) rounded half up to Q0.32.
	// Evaluated at elaboration only.
	function automatic logic [31:0] exp_factor(input int k);
		logic [63:0]  v;
		logic [127:0] p;
		v = EXP_SEED;
		for (int i = 0; i < k; i++) begin
			p = {64'd0, v} * {64'd0, v};
			v = p[127:64];
		end
		return v[63:32] + {31'd0, v[31]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/gtc_div.sv
// ----------------------------------------------------------------------------
// gtc_div
// Pipelined restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_div #(
	parameter int NUM_BITS = 40,
	parameter int DEN_BITS = 17,
	parameter int QUO_BITS = 28
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [NUM_BITS-1:0] num,
	input  wire logic [DEN_BITS-1:0] den,
	input  wire gtc_pkg::tag_t       tag_in,
	output logic      [QUO_BITS-1:0] quo,
	output gtc_pkg::tag_t            tag_out
);

	// work register: numerator bits shift out at the top, quotient bits in at the bottom
	logic [DEN_BITS-1:0] rem_s  [QUO_BITS-1];
	logic [QUO_BITS-1:0] work_s [QUO_BITS];
	gtc_pkg::tag_t       tag_s  [QUO_BITS];

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		logic [DEN_BITS-1:0] rem_in;
		logic [QUO_BITS-1:0] work_in;
		gtc_pkg::tag_t       tag_k;
		logic [DEN_BITS:0]   trial;
		logic [DEN_BITS:0]   diff;
		logic                fits;

		if (i == 0) begin : g_first
			// quotient fits in QUO_BITS, so the top part is already below den
			assign rem_in  = DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
			assign work_in = num[QUO_BITS-1:0];
			assign tag_k   = tag_in;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign work_in = work_s[i-1];
			assign tag_k   = tag_s[i-1];
		end

		assign trial = {rem_in, work_in[QUO_BITS-1]};
		assign diff  = trial - {1'b0, den};
		assign fits  = trial >= {1'b0, den};

		always_ff @(posedge clk) begin
			work_s[i] <= {work_in[QUO_BITS-2:0], fits};
		end

		if (i < QUO_BITS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[i] <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else begin
				tag_s[i] <= tag_k;
			end
		end
	end

	assign quo     = work_s[QUO_BITS-1];
	assign tag_out = tag_s[QUO_BITS-1];

endmodule

`default_nettype wire

// File: rtl/core/gtc_exp.sv
// ----------------------------------------------------------------------------
// gtc_exp
// Pipelined exp(-e): one constant factor multiply per exponent bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_exp #(
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [gtc_pkg::EXP_BITS-1:0] expo,
	input  wire gtc_pkg::tag_t                tag_in,
	output logic      [WEIGHT_BITS:0]         weight,
	output gtc_pkg::tag_t                     tag_out
);

	localparam int N = gtc_pkg::EXP_BITS;

	// accumulator in Q1.32, 1.0 = 2^32
	logic [32:0]   acc_s  [N];
	logic [N-1:0]  expo_s [N-1];
	gtc_pkg::tag_t tag_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [31:0] FACTOR = gtc_pkg::exp_factor(k);

		logic [32:0]   acc_in;
		logic [N-1:0]  expo_in;
		gtc_pkg::tag_t tag_k;
		logic [64:0]   prod;

		if (k == 0) begin : g_first
			assign acc_in  = tag_in.zero ? 33'd0 : {1'b1, 32'd0};
			assign expo_in = expo;
			assign tag_k   = tag_in;
		end else begin : g_next
			assign acc_in  = acc_s[k-1];
			assign expo_in = expo_s[k-1];
			assign tag_k   = tag_s[k-1];
		end

		assign prod = {32'd0, acc_in} * {33'd0, FACTOR};

		always_ff @(posedge clk) begin
			acc_s[k] <= expo_in[k] ? prod[64:32] : acc_in;
		end

		if (k < N - 1) begin : g_expo
			always_ff @(posedge clk) begin
				expo_s[k] <= expo_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else begin
				tag_s[k] <= tag_k;
			end
		end
	end

	assign weight  = acc_s[N-1][32:32-WEIGHT_BITS];
	assign tag_out = tag_s[N-1];

endmodule

`default_nettype wire

// File: rtl/core/gtc_blend.sv
// ----------------------------------------------------------------------------
// gtc_blend
// Two-stage blend of peak and base colors by the curve weight.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_blend #(
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [WEIGHT_BITS:0]   weight,
	input  wire gtc_pkg::tag_t          tag,
	input  wire gtc_pkg::colors_t       colors,
	input  wire logic [WEIGHT_BITS-1:0] base_opacity,
	output logic                        done,
	output logic      [7:0]             red,
	output logic      [7:0]             green,
	output logic      [7:0]             blue,
	output logic      [7:0]             alpha
);

	localparam int W = WEIGHT_BITS;
	localparam logic [W:0] ONE = {1'b1, {W{1'b0}}};

	logic [31:0]    peak;
	logic [23:0]    base;
	logic [W:0]     inv;
	logic [W+7:0]   opa255;

	logic           vld_s1;
	logic           vld_s2;
	logic [W+8:0]   pk_s1 [3];
	logic [W+8:0]   ba_s1 [3];
	logic [W+8:0]   pa_s1;
	logic [2*W+8:0] op_s1;
	logic [7:0]     col_s2 [3];
	logic [7:0]     alpha_s2;
	logic [2*W+9:0] num;

	assign peak   = tag.left ? colors.peak_lo : colors.peak_hi;
	assign base   = tag.left ? colors.base_lo : colors.base_hi;
	assign inv    = ONE - weight;
	assign opa255 = {base_opacity, 8'd0} - {8'd0, base_opacity};

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [W+9:0] sum;

		always_ff @(posedge clk) begin
			pk_s1[c] <= {{(W+1){1'b0}}, peak[31-8*c -: 8]} * {8'd0, weight};
			ba_s1[c] <= {{(W+1){1'b0}}, base[23-8*c -: 8]} * {8'd0, inv};
		end

		assign sum = {1'b0, pk_s1[c]} + {1'b0, ba_s1[c]};

		always_ff @(posedge clk) begin
			col_s2[c] <= sum[W+7:W];
		end
	end

	always_ff @(posedge clk) begin
		pa_s1 <= {{(W+1){1'b0}}, peak[7:0]} * {8'd0, weight};
		op_s1 <= {{(W+1){1'b0}}, opa255} * {{(W+8){1'b0}}, inv};
	end

	assign num = {1'b0, pa_s1, {W{1'b0}}} + {1'b0, op_s1};

	always_ff @(posedge clk) begin
		alpha_s2 <= num[2*W+7:2*W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= tag.valid;
			vld_s2 <= vld_s1;
		end
	end

	assign done  = vld_s2;
	assign red   = col_s2[0];
	assign green = col_s2[1];
	assign blue  = col_s2[2];
	assign alpha = alpha_s2;

endmodule

`default_nettype wire

// File: rtl/core/gaussian_transfer_color.sv
// ----------------------------------------------------------------------------
// gaussian_transfer_color
// Maps volume intensity samples to RGBA through one Gaussian curve.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive sample and raise start; the transaction is taken at a
//    rising edge with start high and busy low. busy is high only while
//    reset is applied and in the first cycle after it, so a new sample can
//    be given every clock cycle.
//  - Output: red/green/blue/alpha are valid for exactly one cycle while done
//    is high. The receiver cannot stall; results must be taken as they come.
//  - Throughput: one transaction per cycle, in order. The pipeline depth is
//    set mostly by the 28-stage divider for the curve exponent and the
//    28-stage chain of exp factor multiplies that follows it.
//  - Configuration: cfg_write/cfg_index/cfg_data write one register per
//    cycle; write only while no transaction is in flight. Unknown indexes
//    are ignored.
//  - Reset (arst_n low): empties the pipeline and loads the register
//    defaults (center 1/2, width 655/65536, zero colors and opacity).
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_transfer_color #(
	parameter int SAMPLE_BITS = 16,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// sample channel
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [SAMPLE_BITS-1:0]                sample,
	// result channel
	output logic                                       done,
	output logic      [7:0]                            red,
	output logic      [7:0]                            green,
	output logic      [7:0]                            blue,
	output logic      [7:0]                            alpha,
	// configuration
	input  wire logic                                  cfg_write,
	input  wire logic [gtc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [gtc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int S        = SAMPLE_BITS;
	localparam int NUM_BITS = S + gtc_pkg::EXP_FRAC;   // scaled d^2
	localparam int DEN_BITS = S + 1;                   // 2*width
	localparam int SHIFT    = gtc_pkg::EXP_FRAC - S;

	localparam logic [S-1:0] CENTER_RESET = {1'b1, {(S-1){1'b0}}};
	localparam logic [S-1:0] WIDTH_RESET  = S'((64'd655 << S) >> 16);

	// configuration registers
	logic [S-1:0]             center_q;
	logic [S-1:0]             width_q;
	logic [WEIGHT_BITS-1:0]   opacity_q;
	gtc_pkg::colors_t         colors_q;
	logic                     busy_q;

	// front pipeline
	logic                     vld_s1, vld_s2, vld_s3;
	logic [S-1:0]             x_s1;
	logic [S-1:0]             d_s2;
	logic                     left_s2, left_s3;
	logic [2*S-1:0]           d2_s3;
	logic [NUM_BITS-1:0]      num_s4;
	gtc_pkg::tag_t            tag_s4;

	logic [S-1:0]             weff;
	logic [S+4:0]             weff24;
	logic [2*S+4:0]           limit;
	logic                     zero;
	logic [DEN_BITS-1:0]      den;

	logic [gtc_pkg::EXP_BITS-1:0] expo;
	gtc_pkg::tag_t                div_tag;
	logic [WEIGHT_BITS:0]         weight;
	gtc_pkg::tag_t                exp_tag;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q  <= CENTER_RESET;
			width_q   <= WIDTH_RESET;
			opacity_q <= '0;
			colors_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				gtc_pkg::REG_CENTER:           center_q         <= cfg_data[S-1:0];
				gtc_pkg::REG_WIDTH:            width_q          <= cfg_data[S-1:0];
				gtc_pkg::REG_BASE_OPACITY:     opacity_q        <= cfg_data[WEIGHT_BITS-1:0];
				gtc_pkg::REG_PEAK_COLOR_LEFT:  colors_q.peak_lo <= cfg_data[31:0];
				gtc_pkg::REG_PEAK_COLOR_RIGHT: colors_q.peak_hi <= cfg_data[31:0];
				gtc_pkg::REG_BASE_COLOR_LEFT:  colors_q.base_lo <= cfg_data[23:0];
				gtc_pkg::REG_BASE_COLOR_RIGHT: colors_q.base_hi <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// busy covers reset and only the cycle right after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// ------------------------------------------------------------------
	// config-derived terms; the user must keep them stable while transactions are in flight
	// ------------------------------------------------------------------
	// zero width behaves as the smallest step
	assign weff   = (width_q == '0) ? S'(1) : width_q;
	assign weff24 = ((S+5)'(weff) << 4) + ((S+5)'(weff) << 3);
	assign limit  = {weff24, {S{1'b0}}};
	assign den    = {weff, 1'b0};

	// ------------------------------------------------------------------
	// s1: capture, s2: distance to center, s3: square, s4: range check
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			tag_s4 <= '0;
		end else begin
			vld_s1       <= start && !busy_q;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			tag_s4.valid <= vld_s3;
			tag_s4.left  <= left_s3;
			tag_s4.zero  <= zero;
		end
	end

	// exponent of 12 or more underflows the weight to zero
	assign zero = {5'd0, d2_s3} >= limit;

	always_ff @(posedge clk) begin
		x_s1    <= sample;
		d_s2    <= (x_s1 >= center_q) ? (x_s1 - center_q) : (center_q - x_s1);
		left_s2 <= x_s1 < center_q;
		d2_s3   <= {{S{1'b0}}, d_s2} * {{S{1'b0}}, d_s2};
		left_s3 <= left_s2;
		// a zeroed numerator keeps the divider well behaved on dropped samples
		num_s4  <= zero ? '0 : (NUM_BITS'(d2_s3) << SHIFT);
	end

	// ------------------------------------------------------------------
	// exponent e = d^2 * 2^24 / (2*width), then weight = exp(-e)
	// ------------------------------------------------------------------
	gtc_div #(
		.NUM_BITS (NUM_BITS),
		.DEN_BITS (DEN_BITS),
		.QUO_BITS (gtc_pkg::EXP_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.num     (num_s4),
		.den     (den),
		.tag_in  (tag_s4),
		.quo     (expo),
		.tag_out (div_tag)
	);

	gtc_exp #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.expo    (expo),
		.tag_in  (div_tag),
		.weight  (weight),
		.tag_out (exp_tag)
	);

	// ------------------------------------------------------------------
	// color and opacity blend, registered outputs
	// ------------------------------------------------------------------
	gtc_blend #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.weight       (weight),
		.tag          (exp_tag),
		.colors       (colors_q),
		.base_opacity (opacity_q),
		.done         (done),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha)
	);

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gaussian_transfer_color. Directed samples cover the
// curve peak, the zero-weight cutoff, a zero width, opacity above peak alpha
// and centers at both ends of the range. Random traffic then runs under
// several register settings. A built-in predictor scores every result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SB = 16;                 // sample bits
	localparam int WB = 16;                 // weight bits
	localparam int LATENCY = 62;            // accept edge to result edge
	localparam int QUIET_LIMIT = 2000;      // cycles with no handshake -> hang
	localparam int PHASE_ITEMS = 60;
	localparam logic [15:0] CENTER_DEFAULT = 16'h8000;
	localparam logic [15:0] WIDTH_DEFAULT = 16'd655;
	// register index with no register behind it; writes must be dropped
	localparam logic [gtc_pkg::CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic [15:0] sample;
		rgba_t       color;
	} pending_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] sample = '0;
	logic        cfg_write = 1'b0;
	logic [gtc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [gtc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic        busy;
	logic        done;
	logic [7:0]  red, green, blue, alpha;

	// shadow copy of the register file, updated on each write edge
	logic [15:0] cur_center, cur_width, cur_opacity;
	logic [31:0] cur_peak_lo, cur_peak_hi;
	logic [23:0] cur_base_lo, cur_base_hi;

	// exp(-2^(k-24)) rounded to Q0.32, one factor per exponent bit
	logic [31:0] exp_step [gtc_pkg::EXP_BITS];

	pending_t expected_colors[$];
	int  errors = 0;
	int  sent = 0;
	int  checked = 0;
	int  settings = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b1;

	always #5 clk = ~clk;

	gaussian_transfer_color #(
		.SAMPLE_BITS(SB),
		.WEIGHT_BITS(WB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Gaussian weight in Q1.16, 65536 meaning exactly 1.0
	function automatic logic [16:0] curve_weight(input logic [15:0] x);
		logic [15:0] d, w;
		logic [63:0] d2, e, acc;
		w = (cur_width == '0) ? 16'd1 : cur_width;   // zero width acts as 1
		d = (x >= cur_center) ? x - cur_center : cur_center - x;
		d2 = 64'(d) * 64'(d);
		// exponent 12 or more: weight flushes to zero
		if (d2 >= ((64'(w) * 64'd24) << SB))
			return '0;
		e = (d2 << (gtc_pkg::EXP_FRAC - SB)) / (64'(w) << 1);
		acc = 64'd1 << 32;
		for (int k = 0; k < gtc_pkg::EXP_BITS; k++)
			if (e[k])
				acc = (acc * 64'(exp_step[k])) >> 32;
		return 17'(acc >> (32 - WB));
	endfunction

	function automatic logic [7:0] mix_channel(input logic [7:0] peak, base,
			input logic [16:0] g);
		logic [31:0] sum;
		sum = 32'(peak) * 32'(g) + 32'(base) * ((32'd1 << WB) - 32'(g));
		return sum[WB+7:WB];
	endfunction

	function automatic rgba_t predict_color(input logic [15:0] x);
		logic [16:0] g;
		logic [31:0] peak;
		logic [23:0] base;
		logic [63:0] num;
		rgba_t c;
		g = curve_weight(x);
		// strictly below center takes the left pair, center itself goes right
		peak = (x < cur_center) ? cur_peak_lo : cur_peak_hi;
		base = (x < cur_center) ? cur_base_lo : cur_base_hi;
		c.red   = mix_channel(peak[31:24], base[23:16], g);
		c.green = mix_channel(peak[23:16], base[15:8], g);
		c.blue  = mix_channel(peak[15:8], base[7:0], g);
		num = ((64'(g) * 64'(peak[7:0])) << WB)
			+ ((64'd1 << WB) - 64'(g)) * 64'd255 * 64'(cur_opacity);
		c.alpha = num[2*WB+7:2*WB];
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: the receiver can't stall, so every done pulse is
	// scored against the oldest pending expectation.
	// ------------------------------------------------------------------
	task automatic check_channel(input string name, input logic [15:0] s,
			input logic [7:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch for sample %h: expected %h, actual %h",
				$time, name, s, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : score_results
		pending_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h %h %h %h",
					$time, red, green, blue, alpha);
				errors++;
			end else begin
				want = expected_colors.pop_front();
				checked++;
				check_channel("red", want.sample, want.color.red, red);
				check_channel("green", want.sample, want.color.green, green);
				check_channel("blue", want.sample, want.color.blue, blue);
				check_channel("alpha", want.sample, want.color.alpha, alpha);
			end
		end
	end

	// hang detection: any transaction, result or register write counts
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1 || cfg_write)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, expected_colors.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// one sample transaction; each cycle ahead of it idles at random when
	// enabled, so about a third of the cycles go idle
	task automatic send_sample(input logic [15:0] s);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 33) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_colors.push_back({s, predict_color(s)});
		sent++;
	endtask

	// drop start and hold until every result in flight has come back
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [gtc_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			gtc_pkg::REG_CENTER:           cur_center = value[15:0];
			gtc_pkg::REG_WIDTH:            cur_width = value[15:0];
			gtc_pkg::REG_BASE_OPACITY:     cur_opacity = value[15:0];
			gtc_pkg::REG_PEAK_COLOR_LEFT:  cur_peak_lo = value;
			gtc_pkg::REG_PEAK_COLOR_RIGHT: cur_peak_hi = value;
			gtc_pkg::REG_BASE_COLOR_LEFT:  cur_base_lo = value[23:0];
			gtc_pkg::REG_BASE_COLOR_RIGHT: cur_base_hi = value[23:0];
			default: ;
		endcase
	endtask

	// full register load while idle; junk above the width of each narrower
	// register must be dropped, and the unmapped index must change nothing
	task automatic set_curve(input logic [15:0] c, w, o,
			input logic [31:0] pl, pr, input logic [23:0] bl, br);
		wait_drained();
		write_reg(gtc_pkg::REG_CENTER, {16'($urandom), c});
		write_reg(gtc_pkg::REG_WIDTH, {16'($urandom), w});
		write_reg(gtc_pkg::REG_BASE_OPACITY, {16'($urandom), o});
		write_reg(gtc_pkg::REG_PEAK_COLOR_LEFT, pl);
		write_reg(gtc_pkg::REG_PEAK_COLOR_RIGHT, pr);
		write_reg(gtc_pkg::REG_BASE_COLOR_LEFT, {8'($urandom), bl});
		write_reg(gtc_pkg::REG_BASE_COLOR_RIGHT, {8'($urandom), br});
		write_reg(REG_NONE, $urandom);
		cfg_write <= 1'b0;
		settings++;
	endtask

	// mostly samples around the peak at spread-out distances, some anywhere
	function automatic logic [15:0] pick_sample();
		int offs, pos;
		case ($urandom_range(0, 9))
			0: return cur_center;
			1, 2, 3: return 16'($urandom);
			default: begin
				offs = $urandom_range(0, 1 << $urandom_range(0, 16));
				pos = int'(cur_center) + ($urandom_range(0, 1) ? offs : -offs);
				if (pos < 0)
					pos = 0;
				if (pos > 65535)
					pos = 65535;
				return 16'(pos);
			end
		endcase
	endfunction

	// phase 0 and 1 pin the extremes, later phases draw at random
	task automatic set_random_curve(input int phase);
		logic [15:0] c, w, o;
		logic [31:0] pl, pr;
		logic [23:0] bl, br;
		c = 16'($urandom);
		o = 16'($urandom);
		pl = $urandom;
		pr = $urandom;
		bl = 24'($urandom);
		br = 24'($urandom);
		case ($urandom_range(0, 3))
			0: w = 16'($urandom_range(0, 64));
			1: w = 16'($urandom_range(0, 4000));
			default: w = 16'($urandom);
		endcase
		if (phase == 0) begin
			c = '1; w = '1; o = '1;
			pl = '1; pr = '1; bl = '1; br = '1;
		end else if (phase == 1) begin
			c = '0; w = 16'd1; o = '0;
			pl = '1; pr = '1; bl = '0; br = '0;
		end
		set_curve(c, w, o, pl, pr, bl, br);
	endtask

	task automatic run_phase(input int phase, input int count, input bit pause_midway);
		set_random_curve(phase);
		for (int n = 0; n < count; n++) begin
			if (pause_midway && n == count / 2)
				wait_drained();
			send_sample(pick_sample());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// register defaults straight out of reset
	task automatic test_default_registers();
		send_sample(CENTER_DEFAULT);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
	endtask

	// peak, both neighbors, range ends and the zero-weight cutoff on each side
	task automatic test_curve_shape();
		// width 100: d = 12541 is the last distance below the zero-weight cutoff
		localparam int CUT_D = 12541;
		set_curve(16'h8000, 16'd100, 16'h4000, 32'hFF80_40C0, 32'h10E0_70FF,
			24'h00FF20, 24'h8040FF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h8001);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'(32768 + CUT_D));
		send_sample(16'(32768 + CUT_D + 1));
		send_sample(16'(32768 - CUT_D));
		send_sample(16'(32768 - CUT_D - 1));
	endtask

	// zero width must behave like width 1: cutoff lies between 1200 and 1300
	task automatic test_zero_width();
		set_curve(16'h4000, 16'd0, 16'h8000, 32'hC0A0_8060, 32'h4080_C0E0,
			24'h0A0B0C, 24'hFFEEDD);
		send_sample(16'h4000);
		send_sample(16'h4001);
		send_sample(16'h3FFF);
		send_sample(16'(16'h4000 + 1200));
		send_sample(16'(16'h4000 + 1300));
	endtask

	// base opacity above the peak alpha: alpha falls toward the peak
	task automatic test_opacity_over_peak();
		set_curve(16'h8000, 16'd100, 16'hFFFF, 32'h2040_6010, 32'h8080_8000,
			24'h102030, 24'hF0E0D0);
		send_sample(16'h8000);
		send_sample(16'h8000 - 16'd200);
		send_sample(16'h8000 + 16'd3000);
	endtask

	// center at either end of the range
	task automatic test_center_extremes();
		set_curve(16'h0000, 16'd2000, 16'h8000, 32'h1122_3344, 32'hAABB_CCDD,
			24'h556677, 24'h8899AA);
		send_sample(16'h0000);
		send_sample(16'h0001);
		send_sample(16'hFFFF);
		set_curve(16'hFFFF, 16'd2000, 16'h8000, 32'h1122_3344, 32'hAABB_CCDD,
			24'h556677, 24'h8899AA);
		send_sample(16'hFFFF);
		send_sample(16'hFFFE);
		send_sample(16'h0000);
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 5; p++)
			run_phase(p, PHASE_ITEMS, 1'b0);
	endtask

	// one transaction per clock, no gaps at all
	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_phase(5, 72, 1'b0);
		idle_on = 1'b1;
	endtask

	// sender holds off midway until the pipeline is empty, then resumes
	task automatic test_pause_midstream();
		run_phase(6, 72, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		logic [63:0]  chain;
		logic [127:0] sq;

		// factor table by repeated squaring of exp(-2^-24)
		chain = gtc_pkg::EXP_SEED;
		for (int k = 0; k < gtc_pkg::EXP_BITS; k++) begin
			exp_step[k] = chain[63:32] + {31'd0, chain[31]};
			sq = {64'd0, chain} * {64'd0, chain};
			chain = sq[127:64];
		end

		cur_center = CENTER_DEFAULT;
		cur_width = WIDTH_DEFAULT;
		cur_opacity = '0;
		cur_peak_lo = '0;
		cur_peak_hi = '0;
		cur_base_lo = '0;
		cur_base_hi = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_default_registers();
		test_curve_shape();
		test_zero_width();
		test_opacity_over_peak();
		test_center_extremes();
		test_random_traffic();
		test_back_to_back();
		test_pause_midstream();

		// let the tail drain, then give a late stray result time to show up
		wait_drained();
		repeat (LATENCY + 8) @(posedge clk);

		$display("Run covered %0d samples across %0d register loads;", sent, settings);
		$display("%0d results scored, %0d mismatches.", checked, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
